// ===== hdl/lzfg_pkg.sv =====
// Shared types and constants for the LZ77 flag-group decoder.
package lzfg_pkg;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_BAD_MATCH = 3'd1;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd2;
   localparam logic [2:0] STATUS_NEG_COUNT = 3'd3;
   localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic       load;      // register the accepted input word
      logic       parse;     // run the parser on the registered word
      logic       copy_step; // emit one copied byte
   } ctrl_type;

   // datapath to controller
   typedef struct packed {
      logic       copy_pending; // parser started a match copy
      logic       copy_last;    // current copy byte is the last one
      logic       has_result;   // parse produced a status-only or literal word
   } stat_type;

endpackage

// ===== hdl/lz77_flag_group_decoder.sv =====
// Top level of the LZ77 flag-group decoder.
// Usage:
//   Feed compressed bytes on req_in_byte with req_stream_start on the first byte
//   of a stream and req_stream_end on the last available byte. A word is taken
//   when req_valid is high and req_stall low.
//   Decoded bytes leave on rsp_* one word per handshake; rsp_run_last marks the
//   last word caused by one input byte; status-only words have
//   rsp_byte_present low.
// Sequencing:
//   Each accepted byte passes through the parse and result states before the
//   next byte is taken; a literal or status word waits out receiver stall. A match
//   then emits one copied byte per cycle while rsp_stall is low, set by the single read port of the history memory.
// Reset:
//   Synchronous reset clears the parser and the controller; the history
//   memory is not cleared and is only read where written in the stream.
// Stall:
//   While rsp_stall is high the result word holds and no input is taken.
module lz77_flag_group_decoder #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int MAX_MATCH     = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_stream_start,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_present,
   output logic       rsp_run_last,
   output logic [2:0] rsp_status,
   output logic       rsp_stream_done
);
   import lzfg_pkg::*;

   ctrl_type ctrl;
   stat_type stat;
   logic     valid_raw;

   lzfg_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(valid_raw), .rsp_stall(rsp_stall),
      .ctrl(ctrl), .stat(stat)
   );

   lzfg_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH), .MAX_MATCH(MAX_MATCH)) u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .in_byte(req_in_byte), .in_start(req_stream_start), .in_end(req_stream_end),
      .out_byte(rsp_out_byte), .out_present(rsp_byte_present),
      .out_last(rsp_run_last), .out_status(rsp_status), .out_done(rsp_stream_done)
   );

   // drop the output state when the parse made no word
   assign rsp_valid = valid_raw && (stat.has_result || stat.copy_pending);
endmodule

// ===== hdl/lzfg_datapath.sv =====
// Datapath: parser registers, history memory and result register.
module lzfg_datapath #(
   parameter int HISTORY_DEPTH = 65536,
   parameter int MAX_MATCH     = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lzfg_pkg::ctrl_type   ctrl,
   output lzfg_pkg::stat_type   stat,
   input  logic [7:0]           in_byte,
   input  logic                 in_start,
   input  logic                 in_end,
   output logic [7:0]           out_byte,
   output logic                 out_present,
   output logic                 out_last,
   output logic [2:0]           out_status,
   output logic                 out_done
);
   import lzfg_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int BW = AW + 1;

   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_HDR2  = 3'd2;
   localparam logic [2:0] PH_HDR3  = 3'd3;
   localparam logic [2:0] PH_FLAG  = 3'd4;
   localparam logic [2:0] PH_TOKEN = 3'd5;
   localparam logic [2:0] PH_MATCH = 3'd6;

   logic [7:0] hist [HISTORY_DEPTH];

   logic [7:0]  byte_ff;
   logic        start_ff, end_ff;
   logic [AW-1:0] wp_ff, wp_in;
   logic [BW-1:0] bw_ff, bw_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] left_ff, left_in;
   logic [7:0]  flags_ff, flags_in;
   logic [2:0]  gidx_ff, gidx_in;
   logic [31:0] fa_ff, fa_in;
   logic        err_ff, err_in;
   logic [1:0]  mb_ff, mb_in;
   logic        done_ff, done_in;
   logic [2:0]  st_ff, st_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        lit_in, lit_ff;
   logic        copy_in, copy_ff;
   logic        event_in;
   logic        hres_ff;
   logic [7:0]  rdata_ff;
   logic        wr_en;
   logic [7:0]  wr_data;
   logic [AW-1:0] wr_addr;

   // stream-scoped state after optional clear
   logic [AW-1:0] wp_c;
   logic [BW-1:0] bw_c;
   logic [2:0]  phase_c, gidx_c, st_c, gidx_nx;
   logic [31:0] left_c, fa_c, left_dec;
   logic [7:0]  flags_c;
   logic        err_c, done_c;
   logic [1:0]  mb_c;
   logic [15:0] off_w, len_w;
   logic [31:0] fa_full;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         byte_ff  <= in_byte;
         start_ff <= in_start;
         end_ff   <= in_end;
      end
   end

   function automatic logic [AW-1:0] wp_next(input logic [AW-1:0] p);
      wp_next = (32'(p) + 1 >= HISTORY_DEPTH) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wp_c = start_ff ? '0 : wp_ff;
      bw_c = start_ff ? '0 : bw_ff;
      phase_c = start_ff ? PH_HDR0 : phase_ff;
      left_c = start_ff ? '0 : left_ff;
      flags_c = start_ff ? '0 : flags_ff;
      gidx_c = start_ff ? '0 : gidx_ff;
      fa_c = start_ff ? '0 : fa_ff;
      err_c = start_ff ? 1'b0 : err_ff;
      mb_c = start_ff ? '0 : mb_ff;
      done_c = start_ff ? 1'b0 : done_ff;
      st_c = start_ff ? STATUS_OK : st_ff;

      wp_in = wp_ff; bw_in = bw_ff; phase_in = phase_ff; left_in = left_ff;
      flags_in = flags_ff; gidx_in = gidx_ff; fa_in = fa_ff; err_in = err_ff;
      mb_in = mb_ff; done_in = done_ff; st_in = st_ff;
      rd_ptr_in = rd_ptr_ff; cnt_in = cnt_ff;
      lit_in = 1'b0; copy_in = 1'b0; event_in = 1'b0;
      wr_en = 1'b0; wr_data = byte_ff; wr_addr = wp_ff;
      left_dec = left_c - 32'd1;
      gidx_nx = gidx_c + 3'd1;
      fa_full = fa_c | ({24'd0, byte_ff} << (5'd8 * {3'd0, mb_c}));
      off_w = fa_full[15:0];
      len_w = fa_full[31:16];

      if (ctrl.parse) begin
         wp_in = wp_c; bw_in = bw_c; phase_in = phase_c; left_in = left_c;
         flags_in = flags_c; gidx_in = gidx_c; fa_in = fa_c; err_in = err_c;
         mb_in = mb_c; done_in = done_c; st_in = st_c;
         if (!err_c && !done_c) begin
            unique case (phase_c)
               PH_HDR1, PH_HDR2, PH_HDR3: begin
                  fa_in = fa_c | ({24'd0, byte_ff} << (5'd8 * {2'd0, phase_c}));
                  phase_in = phase_c + 3'd1;
                  if (phase_c == PH_HDR3) begin
                     left_in = fa_in;
                     gidx_in = '0;
                     if (fa_in[31]) begin
                        err_in = 1'b1; st_in = STATUS_NEG_COUNT;
                     end else if (fa_in == '0) begin
                        done_in = 1'b1;
                     end
                  end
               end
               PH_FLAG: begin
                  flags_in = byte_ff; gidx_in = '0; phase_in = PH_TOKEN;
               end
               PH_TOKEN: begin
                  if (flags_c[gidx_c]) begin
                     fa_in = {24'd0, byte_ff}; mb_in = 2'd1; phase_in = PH_MATCH;
                  end else begin
                     wr_en = 1'b1; lit_in = 1'b1; wr_addr = wp_c;
                     wp_in = wp_next(wp_c);
                     if (32'(bw_c) < HISTORY_DEPTH) bw_in = bw_c + 1'b1;
                     left_in = left_dec;
                     if (left_dec == '0) done_in = 1'b1;
                     else begin
                        gidx_in = gidx_nx;
                        phase_in = (gidx_nx == 3'd0) ? PH_FLAG : PH_TOKEN;
                     end
                  end
               end
               PH_MATCH: begin
                  fa_in = fa_full;
                  mb_in = mb_c + 2'd1;
                  if (mb_c == 2'd3) begin
                     mb_in = '0;
                     if (off_w == '0 || len_w == '0 || {1'b0, off_w} > 17'(bw_c)) begin
                        err_in = 1'b1; st_in = STATUS_BAD_MATCH;
                     end else if (32'(len_w) > MAX_MATCH) begin
                        err_in = 1'b1; st_in = STATUS_TOO_LONG;
                     end else begin
                        copy_in = 1'b1;
                        cnt_in = 7'(len_w);
                        // step back by offset, wrapping below slot zero
                        rd_ptr_in = (32'(wp_c) >= 32'(off_w))
                                    ? AW'(32'(wp_c) - 32'(off_w))
                                    : AW'(32'(wp_c) + HISTORY_DEPTH - 32'(off_w));
                        left_in = left_dec;
                        if (left_dec == '0) done_in = 1'b1;
                        else begin
                           gidx_in = gidx_nx;
                           phase_in = (gidx_nx == 3'd0) ? PH_FLAG : PH_TOKEN;
                        end
                     end
                  end
               end
               default: begin
                  fa_in = {24'd0, byte_ff}; phase_in = PH_HDR1;
               end
            endcase
            if (end_ff && !err_in && !done_in) begin
               err_in = 1'b1; st_in = STATUS_TRUNCATED;
            end
            event_in = err_in || done_in;
         end
      end

      if (ctrl.copy_step) begin
         wr_en = 1'b1; wr_data = rdata_ff; wr_addr = wp_ff;
         wp_in = wp_next(wp_ff);
         if (32'(bw_ff) < HISTORY_DEPTH) bw_in = bw_ff + 1'b1;
         rd_ptr_in = wp_next(rd_ptr_ff);
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; bw_ff <= '0; phase_ff <= PH_HDR0; left_ff <= '0;
         flags_ff <= '0; gidx_ff <= '0; fa_ff <= '0; err_ff <= 1'b0;
         mb_ff <= '0; done_ff <= 1'b0; st_ff <= STATUS_OK;
         lit_ff <= 1'b0; copy_ff <= 1'b0; hres_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; bw_ff <= bw_in; phase_ff <= phase_in; left_ff <= left_in;
         flags_ff <= flags_in; gidx_ff <= gidx_in; fa_ff <= fa_in; err_ff <= err_in;
         mb_ff <= mb_in; done_ff <= done_in; st_ff <= st_in; cnt_ff <= cnt_in;
         if (ctrl.parse) begin
            lit_ff <= lit_in; copy_ff <= copy_in; hres_ff <= lit_in || event_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      if (wr_en) hist[wr_addr] <= wr_data;
   end

   // forward the byte being written when an overlapping copy reads it next
   always_ff @(posedge clock) begin
      rdata_ff <= (wr_en && (wr_addr == rd_ptr_in)) ? wr_data : hist[rd_ptr_in];
   end

   assign stat.copy_pending = copy_ff;
   assign stat.copy_last = (cnt_ff == 7'd1);
   assign stat.has_result = hres_ff;

   assign out_byte = copy_ff ? rdata_ff : (lit_ff ? byte_ff : 8'd0);
   assign out_present = copy_ff || lit_ff;
   assign out_last = !copy_ff || (cnt_ff == 7'd1);
   assign out_status = st_ff;
   assign out_done = err_ff || done_ff;
endmodule

// ===== hdl/lzfg_control.sv =====
// Controller: sequences accept, parse, copy and result handshake.
module lzfg_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lzfg_pkg::ctrl_type ctrl,
   input  lzfg_pkg::stat_type stat
);
   import lzfg_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PARSE = 2'd1;
   localparam logic [1:0] S_OUT   = 2'd2;
   localparam logic [1:0] S_COPY  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept = req_valid && !req_stall;
   // a pending copy emits its words from S_COPY only
   assign rsp_valid = ((state_ff == S_OUT) && stat.has_result && !stat.copy_pending) ||
                      (state_ff == S_COPY);

   always_comb begin
      state_in = state_ff;
      ctrl.load = accept;
      ctrl.parse = (state_ff == S_PARSE);
      ctrl.copy_step = (state_ff == S_COPY) && !rsp_stall;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_PARSE;
         S_PARSE: state_in = S_OUT;
         S_OUT: begin
            // parse result registers are now visible
            if (stat.copy_pending) state_in = S_COPY;
            else if (!stat.has_result) state_in = S_IDLE;
            else if (!rsp_stall) state_in = S_IDLE;
         end
         S_COPY:  if (!rsp_stall && stat.copy_last) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
